// File: rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants and controller/datapath interface types for the teletype
// cursor controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int PAGE_COUNT  = 8;
  localparam int TAB_STOP    = 8;
  localparam int MAX_RESULTS = 8;

  localparam int PageIdxW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CntW     = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam int InDataW  = 40;
  localparam int OutDataW = 72;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Opcodes carried in the input tuser.
  localparam logic OP_TELETYPE   = 1'b0;
  localparam logic OP_SET_CURSOR = 1'b1;

  // Character codes with a control meaning.
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_COLUMN_COUNT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_PAGE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_BYTES    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DISPLAY_START = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the input item and read the page cursor
    logic step;   // process one character or one tab space
    logic emit;   // form the result into the output register
  } tcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic set_op;    // input item is a set cursor request
    logic page_ok;   // input page selects an existing page
    logic last;      // the result being formed ends the item
    logic out_free;  // the output register can take a result
  } tcc_status_t;

endpackage

// File: rtl/core/teletype_cursor_controller_core.sv
// ----------------------------------------------------------------------------
// teletype_cursor_controller_core
// Text-mode teletype engine with per-page cursors and hardware cursor address.
// ----------------------------------------------------------------------------
// The block takes one item at a time. An ordinary character passes through
// the accept, step and result states before its single result is formed, and
// a set cursor request skips the step; the next item is accepted in the cycle
// after the final result enters the output register. A tab gives one result
// per space, with a step before each, up to eight. The single row times column
// multiplier serves both the cursor read at acceptance and the hardware cursor
// address of each result. A stalled output holds the sequence at the result
// stage. The configuration channel is always ready.
module teletype_cursor_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Fields from bit 0 up: char_code[7:0], char_attr[15:8], attr_enable[16],
  // page_sel[19:17], new_row[27:20], new_col[35:28], zero fill.
  input  logic [tcc_pkg::InDataW-1:0]  s_tdata_i,
  // Fields: opcode[0].
  input  logic                         s_tuser_i,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  // Fields from bit 0 up: write_valid[0], write_char[8:1], write_attr[16:9],
  // attr_valid[17], write_address[33:18], scroll_up[34], beep[35],
  // cursor_row[43:36], cursor_col[51:44], hw_cursor_valid[52],
  // hw_cursor_address[68:53], zero fill.
  output logic [tcc_pkg::OutDataW-1:0] m_tdata_o,
  output logic                         m_tlast_o,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tcc_pkg::CfgDataW-1:0] cfg_data_i
);
  import tcc_pkg::*;

  tcc_cmd_t    cmd;
  tcc_status_t status;

  assign cfg_ready_o = 1'b1;

  tcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tready_i  (m_tready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_tvalid_o),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

endmodule

// File: rtl/core/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer for the teletype cursor controller: accepts items, steps through
// characters and tab spaces and hands each result to the output register.
// ----------------------------------------------------------------------------
module tcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  tcc_pkg::tcc_status_t status_i,
  output tcc_pkg::tcc_cmd_t    cmd_o
);
  import tcc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        // An item for a page that does not exist is taken and dropped.
        if (s_tvalid_i && status_i.page_ok) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.set_op ? ST_EMIT : ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.last ? ST_IDLE : ST_STEP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/tcc_datapath.sv
// ----------------------------------------------------------------------------
// tcc_datapath
// Configuration registers, per-page cursor store, character interpretation,
// address arithmetic and the output register of the teletype controller.
// ----------------------------------------------------------------------------
module tcc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [tcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tcc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [tcc_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         s_tuser_i,
  input  logic                         m_tready_i,
  input  tcc_pkg::tcc_cmd_t            cmd_i,
  output tcc_pkg::tcc_status_t         status_o,
  output logic                         m_tvalid_o,
  output logic [tcc_pkg::OutDataW-1:0] m_tdata_o,
  output logic                         m_tlast_o
);
  import tcc_pkg::*;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       scr;
  } cursor_t;

  // Configuration registers.
  logic [7:0]  cols_q, rows_q;
  logic [2:0]  active_q;
  logic [15:0] page_bytes_q, disp_start_q;

  // Cursor store: row in the upper byte, column in the lower byte.
  logic [15:0] store_q [PAGE_COUNT];

  // Input fields.
  logic [7:0] in_char, in_attr, in_row, in_col;
  logic       in_ae;
  logic [2:0] in_page;

  // Working registers of the item in progress.
  logic [2:0]      page_q;
  logic [7:0]      char_q, attr_q;
  logic            ae_q, tab_q;
  logic [7:0]      row_q, col_q;
  logic [15:0]     lin_q, page_off_q;
  logic [CntW-1:0] cnt_q;
  logic            last_q;

  // Result fields formed in the step.
  logic        wv_q, av_q, scr_q, beep_q;
  logic [7:0]  wch_q, wattr_q;
  logic [15:0] waddr_q;

  // Output register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;

  logic [15:0] store_rd;
  logic [7:0]  mul_row;
  logic [15:0] prod;

  logic [7:0]  ch;
  cursor_t     c0, s1, s2, fin;
  logic        wv, bp, tab_last, last_n;
  logic [15:0] lin_col, waddr;
  logic        hwv;
  logic [15:0] hwa;

  function automatic cursor_t settle(cursor_t c, logic [7:0] cols, logic [7:0] rows);
    cursor_t r;
    r     = c;
    r.scr = 1'b0;
    if (r.col == cols) begin
      r.col = 8'd0;
      r.row = r.row + 8'd1;
    end
    if (r.row == rows) begin
      r.scr = 1'b1;
      r.row = r.row - 8'd1;
    end
    return r;
  endfunction

  assign in_char = s_tdata_i[7:0];
  assign in_attr = s_tdata_i[15:8];
  assign in_ae   = s_tdata_i[16];
  assign in_page = s_tdata_i[19:17];
  assign in_row  = s_tdata_i[27:20];
  assign in_col  = s_tdata_i[35:28];

  assign store_rd = store_q[in_page[PageIdxW-1:0]];

  // One row-times-columns multiplier, used at load and when forming a result.
  assign mul_row = cmd_i.load ? store_rd[15:8] : row_q;
  assign prod    = {8'd0, mul_row} * {8'd0, cols_q};

  always_comb begin
    ch       = tab_q ? CH_SPACE : char_q;
    c0.row   = row_q;
    c0.col   = col_q;
    c0.scr   = 1'b0;
    wv       = 1'b0;
    bp       = 1'b0;
    waddr    = '0;
    lin_col  = lin_q + {8'd0, col_q};
    case (ch)
      CH_BEL: bp = 1'b1;
      CH_BS: begin
        if (c0.col != 8'd0) c0.col = c0.col - 8'd1;
      end
      CH_CR: c0.col = 8'd0;
      CH_LF: c0.row = c0.row + 8'd1;
      default: begin
        wv     = 1'b1;
        waddr  = page_off_q + {lin_col[14:0], 1'b0};
        c0.col = c0.col + 8'd1;
      end
    endcase
    s1       = settle(c0, cols_q, rows_q);
    tab_last = tab_q && (((s1.col % 8'(TAB_STOP)) == 8'd0) ||
                         (cnt_q == CntW'(MAX_RESULTS - 1)));
    last_n   = !tab_q || tab_last;
    // The closing check after a tab run only matters with zero columns.
    s2       = settle(s1, cols_q, rows_q);
    fin      = s1;
    if (tab_last) begin
      fin     = s2;
      fin.scr = s1.scr | s2.scr;
    end
  end

  assign hwv = (page_q == active_q);
  assign hwa = hwv ? (prod + {8'd0, col_q} + {1'b0, disp_start_q[15:1]}) : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q       <= 8'd80;
      rows_q       <= 8'd25;
      active_q     <= 3'd0;
      page_bytes_q <= 16'd4096;
      disp_start_q <= 16'd0;
      for (int i = 0; i < PAGE_COUNT; i++) store_q[i] <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      last_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_COLUMN_COUNT:  cols_q       <= cfg_data_i[7:0];
          CFG_ROW_COUNT:     rows_q       <= cfg_data_i[7:0];
          CFG_ACTIVE_PAGE:   active_q     <= cfg_data_i[2:0];
          CFG_PAGE_BYTES:    page_bytes_q <= cfg_data_i;
          CFG_DISPLAY_START: disp_start_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cnt_q  <= '0;
        last_q <= (s_tuser_i == OP_SET_CURSOR);
        if (s_tuser_i == OP_SET_CURSOR) begin
          store_q[in_page[PageIdxW-1:0]] <= {in_row, in_col};
        end
      end
      if (cmd_i.step) begin
        cnt_q                         <= cnt_q + CntW'(1);
        last_q                        <= last_n;
        store_q[page_q[PageIdxW-1:0]] <= {fin.row, fin.col};
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q     <= in_page;
      char_q     <= in_char;
      attr_q     <= in_attr;
      ae_q       <= in_ae;
      tab_q      <= (s_tuser_i == OP_TELETYPE) && (in_char == CH_TAB);
      page_off_q <= 16'({13'd0, in_page} * page_bytes_q);
      wv_q       <= 1'b0;
      wch_q      <= 8'd0;
      wattr_q    <= 8'd0;
      av_q       <= 1'b0;
      waddr_q    <= 16'd0;
      scr_q      <= 1'b0;
      beep_q     <= 1'b0;
      if (s_tuser_i == OP_SET_CURSOR) begin
        row_q <= in_row;
        col_q <= in_col;
      end else begin
        row_q <= store_rd[15:8];
        col_q <= store_rd[7:0];
        lin_q <= prod;
      end
    end
    if (cmd_i.step) begin
      row_q   <= fin.row;
      col_q   <= fin.col;
      wv_q    <= wv;
      wch_q   <= wv ? ch : 8'd0;
      wattr_q <= wv ? attr_q : 8'd0;
      av_q    <= wv & ae_q;
      waddr_q <= waddr;
      scr_q   <= fin.scr;
      beep_q  <= bp;
    end
    if (cmd_i.emit) begin
      // The cursor after this result starts the next tab space.
      lin_q      <= prod;
      out_last_q <= last_q;
      out_data_q <= {3'd0, hwa, hwv, col_q, row_q, beep_q, scr_q, waddr_q,
                     av_q, wattr_q, wch_q, wv_q};
    end
  end

  assign status_o.set_op   = (s_tuser_i == OP_SET_CURSOR);
  assign status_o.page_ok  = ({1'b0, in_page} < 4'(PAGE_COUNT));
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

endmodule

// File: test/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Watches the input, output and configuration channels of the teletype
// cursor controller, keeps its own copy of the page cursors and settings,
// predicts the cursor updates of every accepted item and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tcc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tcc_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         s_tuser_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [tcc_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         m_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [tcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tcc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import tcc_pkg::*;

  typedef struct packed {
    logic        write_valid;
    logic [7:0]  write_char;
    logic [7:0]  write_attr;
    logic        attr_valid;
    logic [15:0] write_address;
    logic        scroll_up;
    logic        beep;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic        hw_cursor_valid;
    logic [15:0] hw_cursor_address;
    logic        last;
  } cursor_update_t;

  logic [7:0]     row_of [PAGE_COUNT];
  logic [7:0]     col_of [PAGE_COUNT];
  logic [7:0]     columns;
  logic [7:0]     rows;
  logic [2:0]     shown_page;
  logic [15:0]    bytes_per_page;
  logic [15:0]    start_bytes;
  cursor_update_t cursor_updates_q [$];
  int             fails = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Wrap when the column count is reached, then scroll when the row count is reached.
  task automatic wrap_and_scroll(inout logic [7:0] row, inout logic [7:0] col,
                                 output logic scrolled);
    scrolled = 1'b0;
    if (col == columns) begin
      col = 8'd0;
      row = row + 8'd1;
    end
    if (row == rows) begin
      scrolled = 1'b1;
      row = row - 8'd1;
    end
  endtask

  task automatic show_cursor(inout cursor_update_t upd, input int unsigned page);
    logic [31:0] hw;
    upd.cursor_row = row_of[page];
    upd.cursor_col = col_of[page];
    upd.hw_cursor_valid = (page == shown_page);
    hw = columns * row_of[page] + col_of[page] + (start_bytes >> 1);
    upd.hw_cursor_address = upd.hw_cursor_valid ? hw[15:0] : 16'd0;
  endtask

  task automatic type_char(input logic [7:0] ch, input logic [7:0] attr, input logic ae,
                           input int unsigned page, output cursor_update_t upd);
    logic [7:0]  row;
    logic [7:0]  col;
    logic        scrolled;
    logic [31:0] addr;
    row = row_of[page];
    col = col_of[page];
    upd = '0;
    case (ch)
      CH_BEL: upd.beep = 1'b1;
      CH_BS: if (col != 8'd0) col = col - 8'd1;
      CH_CR: col = 8'd0;
      CH_LF: row = row + 8'd1;
      default: begin
        addr = page * bytes_per_page + (row * columns + col) * 2;
        upd.write_valid   = 1'b1;
        upd.write_char    = ch;
        upd.write_attr    = attr;
        upd.attr_valid    = ae;
        upd.write_address = addr[15:0];
        col = col + 8'd1;
      end
    endcase
    wrap_and_scroll(row, col, scrolled);
    upd.scroll_up = scrolled;
    row_of[page] = row;
    col_of[page] = col;
    show_cursor(upd, page);
  endtask

  task automatic predict_item(input logic opcode, input logic [InDataW-1:0] data);
    logic [7:0]     ch;
    logic [7:0]     attr;
    logic [7:0]     row;
    logic [7:0]     col;
    logic           ae;
    logic           scrolled;
    int unsigned    page;
    int unsigned    n;
    int unsigned    i;
    cursor_update_t spaces [MAX_RESULTS];
    cursor_update_t upd;
    ch   = data[7:0];
    attr = data[15:8];
    ae   = data[16];
    page = {29'd0, data[19:17]};
    if (page < PAGE_COUNT) begin
      if (opcode == OP_SET_CURSOR) begin
        upd = '0;
        row_of[page] = data[27:20];
        col_of[page] = data[35:28];
        show_cursor(upd, page);
        upd.last = 1'b1;
        cursor_updates_q.push_back(upd);
      end else if (ch == CH_TAB) begin
        n = 0;
        do begin
          type_char(CH_SPACE, attr, ae, page, spaces[n]);
          n++;
        end while (col_of[page] % TAB_STOP != 0 && n < MAX_RESULTS);
        // A second wrap check after the spaces only matters for a zero column count.
        row = row_of[page];
        col = col_of[page];
        wrap_and_scroll(row, col, scrolled);
        row_of[page] = row;
        col_of[page] = col;
        if (scrolled) spaces[n-1].scroll_up = 1'b1;
        show_cursor(spaces[n-1], page);
        spaces[n-1].last = 1'b1;
        for (i = 0; i < n; i++) cursor_updates_q.push_back(spaces[i]);
      end else begin
        type_char(ch, attr, ae, page, upd);
        upd.last = 1'b1;
        cursor_updates_q.push_back(upd);
      end
    end
  endtask

  task automatic check_result();
    cursor_update_t            want;
    logic [OutDataW-1:0]       d;
    d = m_tdata_i;
    if (cursor_updates_q.size() == 0) begin
      report_mismatch($sformatf("result %h with no prediction waiting", d));
    end else begin
      want = cursor_updates_q.pop_front();
      check_field("write_valid", 16'(d[0]), 16'(want.write_valid));
      check_field("write_char", 16'(d[8:1]), 16'(want.write_char));
      check_field("write_attr", 16'(d[16:9]), 16'(want.write_attr));
      check_field("attr_valid", 16'(d[17]), 16'(want.attr_valid));
      check_field("write_address", d[33:18], want.write_address);
      check_field("scroll_up", 16'(d[34]), 16'(want.scroll_up));
      check_field("beep", 16'(d[35]), 16'(want.beep));
      check_field("cursor_row", 16'(d[43:36]), 16'(want.cursor_row));
      check_field("cursor_col", 16'(d[51:44]), 16'(want.cursor_col));
      check_field("hw_cursor_valid", 16'(d[52]), 16'(want.hw_cursor_valid));
      check_field("hw_cursor_address", d[68:53], want.hw_cursor_address);
      check_field("last", 16'(m_tlast_i), 16'(want.last));
    end
  endtask

  always @(posedge clk_i) begin : watch
    int p;
    if (!rst_ni) begin
      for (p = 0; p < PAGE_COUNT; p++) begin
        row_of[p] = 8'd0;
        col_of[p] = 8'd0;
      end
      columns        = 8'd80;
      rows           = 8'd25;
      shown_page     = 3'd0;
      bytes_per_page = 16'd4096;
      start_bytes    = 16'd0;
      cursor_updates_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_COLUMN_COUNT:  columns = cfg_data_i[7:0];
          CFG_ROW_COUNT:     rows = cfg_data_i[7:0];
          CFG_ACTIVE_PAGE:   shown_page = cfg_data_i[2:0];
          CFG_PAGE_BYTES:    bytes_per_page = cfg_data_i;
          CFG_DISPLAY_START: start_bytes = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i) predict_item(s_tuser_i, s_tdata_i);
    end
    fail_count_o <= fails;
    pending_o    <= cursor_updates_q.size();
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the teletype cursor controller: a directed run
// over control characters, tabs, wraps, scrolls and extreme settings, then
// random phases under different idle patterns, checked by tcc_checker.
// ----------------------------------------------------------------------------
module tb;
  import tcc_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic [InDataW-1:0]  s_tdata_i   = '0;
  logic                s_tuser_i   = 1'b0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  logic [OutDataW-1:0] m_tdata_o;
  logic                m_tlast_o;
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  int                  fail_count;
  int                  pending;
  idle_mode_e          idle_mode   = IDLE_NONE;
  logic                hold_req    = 1'b0;
  logic [7:0]          screen_cols = 8'd80;
  logic [7:0]          screen_rows = 8'd25;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  teletype_cursor_controller_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tcc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .m_tdata_i    (m_tdata_o),
    .m_tlast_i    (m_tlast_o),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    #2400000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic idle_draw(input logic receiver_side);
    int unsigned pct;
    pct = 0;
    if (idle_mode == IDLE_BOTH) pct = 36;
    else if (idle_mode == (receiver_side ? IDLE_RECEIVER : IDLE_SENDER)) pct = 79;
    return $urandom_range(99) < pct;
  endfunction

  // A hold request stalls the output for a long stretch so that the block
  // fills up and holds off its input.
  initial begin : receiver
    int unsigned hold_left;
    logic        hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= !idle_draw(1'b1);
      end
    end
  end

  task automatic send_item(input logic opcode, input logic [7:0] ch, input logic [7:0] attr,
                           input logic ae, input logic [2:0] page, input logic [7:0] row,
                           input logic [7:0] col);
    while (idle_draw(1'b0)) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tuser_i  <= opcode;
    s_tdata_i  <= {4'd0, col, row, page, ae, attr, ch};
    s_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  task automatic put_char(input logic [7:0] ch, input logic [7:0] attr, input logic ae,
                          input logic [2:0] page);
    send_item(OP_TELETYPE, ch, attr, ae, page, 8'($urandom), 8'($urandom));
  endtask

  task automatic set_cursor(input logic [2:0] page, input logic [7:0] row,
                            input logic [7:0] col);
    send_item(OP_SET_CURSOR, 8'($urandom), 8'($urandom), 1'($urandom), page, row, col);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] cols, input logic [7:0] rows,
                           input logic [2:0] page, input logic [15:0] pbytes,
                           input logic [15:0] start);
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_reg(CFG_COLUMN_COUNT, {8'd0, cols});
    write_reg(CFG_ROW_COUNT, {8'd0, rows});
    write_reg(CFG_ACTIVE_PAGE, {13'd0, page});
    write_reg(CFG_PAGE_BYTES, pbytes);
    write_reg(CFG_DISPLAY_START, start);
    cfg_valid_i <= 1'b0;
    screen_cols = cols;
    screen_rows = rows;
  endtask

  initial begin : stimulus
    int         ph;
    logic [7:0] c;
    logic [7:0] r;
    logic [7:0] ch;
    logic [7:0] row;
    logic [7:0] col;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 80 columns, 25 rows, page 0 shown.
    put_char(8'h41, 8'hFF, 1'b1, 3'd0);
    put_char(CH_BEL, 8'h00, 1'b0, 3'd0);
    put_char(CH_BS, 8'h00, 1'b0, 3'd0);
    put_char(CH_BS, 8'h00, 1'b0, 3'd0);
    put_char(CH_TAB, 8'h1E, 1'b1, 3'd0);
    put_char(8'h00, 8'h00, 1'b0, 3'd0);
    put_char(CH_TAB, 8'hA5, 1'b0, 3'd0);
    put_char(CH_CR, 8'h00, 1'b0, 3'd0);
    put_char(CH_LF, 8'h00, 1'b0, 3'd0);
    set_cursor(3'd0, 8'd24, 8'd79);
    put_char(8'hFF, 8'h5A, 1'b1, 3'd0);
    put_char(CH_LF, 8'h00, 1'b0, 3'd0);
    // A tab near the right edge wraps onto the next row and stops there.
    set_cursor(3'd5, 8'd3, 8'd77);
    put_char(CH_TAB, 8'h07, 1'b1, 3'd5);
    set_cursor(3'd3, 8'd255, 8'd255);
    put_char(8'h5A, 8'h12, 1'b1, 3'd3);
    put_char(8'h7E, 8'h00, 1'b0, 3'd7);

    // Zero sizes: the tab runs past column 255 and wraps twice on column zero.
    configure(8'd0, 8'd0, 3'd3, 16'hFFFF, 16'hFFFF);
    set_cursor(3'd3, 8'd254, 8'd250);
    put_char(CH_TAB, 8'h3C, 1'b1, 3'd3);
    put_char(8'h61, 8'hC3, 1'b0, 3'd3);
    put_char(CH_LF, 8'h00, 1'b0, 3'd3);
    put_char(CH_LF, 8'h00, 1'b0, 3'd3);

    configure(8'd255, 8'd255, 3'd7, 16'd0, 16'd1);
    set_cursor(3'd7, 8'd254, 8'd253);
    put_char(8'h80, 8'h81, 1'b1, 3'd7);
    put_char(8'h41, 8'h7F, 1'b0, 3'd7);

    for (ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        c = 8'd1;
        r = 8'd1;
      end else begin
        c = 8'(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 12));
        r = 8'(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 6));
      end
      configure(c, r, 3'($urandom), 16'($urandom), 16'($urandom));
      idle_mode = idle_mode_e'(ph % 4);
      if (ph == 4) hold_req = 1'b1;
      repeat (52) begin
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(3))
            0: begin
              row = 8'($urandom);
              col = 8'($urandom);
            end
            1: begin
              row = screen_rows - 8'd1;
              col = screen_cols - 8'd1 - 8'($urandom_range(3));
            end
            default: begin
              row = (screen_rows == 8'd0) ? 8'($urandom) : 8'($urandom % screen_rows);
              col = (screen_cols == 8'd0) ? 8'($urandom) : 8'($urandom % screen_cols);
            end
          endcase
          set_cursor(3'($urandom), row, col);
        end else begin
          case ($urandom_range(9))
            0: ch = CH_BEL;
            1: ch = CH_BS;
            2: ch = CH_CR;
            3: ch = CH_LF;
            4: ch = CH_TAB;
            default: ch = 8'($urandom);
          endcase
          put_char(ch, 8'($urandom), 1'($urandom), 3'($urandom));
        end
      end
    end

    wait_drained();
    repeat (24) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tcc_pkg.sv
rtl/core/tcc_ctrl.sv
rtl/core/tcc_datapath.sv
rtl/core/teletype_cursor_controller_core.sv
test/tcc_checker.sv
test/tb.sv
